// ===== hw/rtl/best_fit_segment_allocator_macros.svh =====
// Assertion macros used by the allocator's checker
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BFSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// next-cycle implication
`define BFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

// ===== hw/rtl/bfsa_pkg.sv =====
// Shared types and constants of the best-fit segment allocator
`default_nettype none
package bfsa_pkg;

    localparam int FREE_SLOTS_DEF = 16;
    localparam int USED_SLOTS_DEF = 16;
    localparam int ADDR_BITS_DEF  = 16;

    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_TOTAL_SIZE = 1'b0;
    localparam logic [15:0] TOTAL_SIZE_RST = 16'hFFFF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_NOID  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/best_fit_segment_allocator.sv =====
// Allocate scans both tables over the larger table depth, commits and registers the result;
// free scans the used table for the job, latches the hit, scans the free table, commits and
// ages the used table in a last scan. One command at a time; one scan index walks the tables
// via one registered read port each; ready rises in the cycle after the result is registered.
// Reset and a total_size write spend one cycle rebuilding the free table before the next beat.
// Reset is synchronous, active low; a result waiting on the output does not stall input accept.
`default_nettype none
module best_fit_segment_allocator
    import bfsa_pkg::*;
#(
    parameter int FREE_SLOTS = FREE_SLOTS_DEF,
    parameter int USED_SLOTS = USED_SLOTS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [31:0]        i_s_tdata,   // job_id[15:0], req_size[31:16]
    input  wire logic [0:0]         i_s_tuser,   // cmd[0]
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [31:0]             o_m_tdata,   // block_begin[15:0], block_size[31:16]
    output logic [1:0]              o_m_tuser,   // status[1:0]
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int FW     = $clog2(FREE_SLOTS);
    localparam int UW     = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam int SCAN_N = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
    localparam int SW     = $clog2(SCAN_N + 1);
    localparam int AW     = ADDR_BITS;
    localparam int CW     = (AW > 16) ? AW : 16;
    localparam logic [AW-1:0] AMAX = {AW{1'b1}};

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ASCAN, S_ACOMMIT, S_FSCAN, S_FREAD, S_FLATCH,
        S_FSCAN2, S_FCOMMIT, S_AGE, S_PUT
    } t_state;

    t_state r_state;

    logic [15:0] r_total;
    logic [FREE_SLOTS-1:0] r_fv;
    logic [USED_SLOTS-1:0] r_uv;

    logic [AW-1:0] r_fb_mem [FREE_SLOTS];
    logic [AW-1:0] r_fe_mem [FREE_SLOTS];
    logic [15:0]   r_uo_mem [USED_SLOTS];
    logic [AW-1:0] r_ub_mem [USED_SLOTS];
    logic [AW-1:0] r_ue_mem [USED_SLOTS];
    logic [UW-1:0] r_ua_mem [USED_SLOTS];

    logic [AW-1:0] r_fb_q, r_fe_q, r_ub_q, r_ue_q;
    logic [15:0]   r_uo_q;
    logic [UW-1:0] r_ua_q;

    logic          r_cmd;
    logic [15:0]   r_job, r_req;
    logic [SW-1:0] r_idx;

    logic          r_bfound;
    logic [FW-1:0] r_bidx;
    logic [AW-1:0] r_bsize, r_bbeg, r_bend;
    logic          r_uslotf;
    logic [UW-1:0] r_uslot;
    logic [UW:0]   r_cnt;

    logic          r_hitf;
    logic [UW-1:0] r_hit, r_hitage;
    logic [AW-1:0] r_b, r_e, r_rend;
    logic          r_leftf, r_rightf, r_fslotf;
    logic [FW-1:0] r_left, r_right, r_fslot;

    t_status       r_rs;
    logic [15:0]   r_rb, r_rz;
    logic          r_ovalid;
    t_status       r_ost;
    logic [15:0]   r_ob, r_oz;

    logic [AW-1:0] w_lim, w_sz, w_nbeg;
    logic [SW-1:0] w_e;
    logic          w_eval, w_ein_f, w_ein_u, w_fits, w_better, w_cfg_wr, w_put;
    logic [UW-1:0] w_urd;
    logic [FW-1:0] w_frd;

    assign w_lim    = (CW'(r_total) > CW'(AMAX)) ? AMAX : AW'(r_total);
    assign w_e      = r_idx - SW'(1);
    assign w_eval   = (r_idx != '0);
    assign w_ein_f  = w_eval && (w_e < SW'(FREE_SLOTS));
    assign w_ein_u  = w_eval && (w_e < SW'(USED_SLOTS));
    assign w_sz     = r_fe_q - r_fb_q;
    assign w_fits   = (r_req != 16'd0) && (CW'(w_sz) >= CW'(r_req));
    assign w_better = !r_bfound || (w_sz < r_bsize) ||
                      ((w_sz == r_bsize) && (r_fb_q < r_bbeg));
    assign w_nbeg   = AW'(CW'(r_bbeg) + CW'(r_req));
    assign w_urd    = (r_state == S_FREAD) ? r_hit : r_idx[UW-1:0];
    assign w_frd    = r_idx[FW-1:0];
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL_SIZE);
    assign w_put    = (r_state == S_PUT) && (!r_ovalid || i_m_tready) && !w_cfg_wr;

    always_ff @(posedge i_clk) begin
        r_fb_q <= r_fb_mem[w_frd];
        r_fe_q <= r_fe_mem[w_frd];
        r_uo_q <= r_uo_mem[w_urd];
        r_ub_q <= r_ub_mem[w_urd];
        r_ue_q <= r_ue_mem[w_urd];
        r_ua_q <= r_ua_mem[w_urd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_total  <= TOTAL_SIZE_RST;
            r_fv     <= '0;
            r_uv     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_put) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_total <= pwdata[15:0];
                r_state <= S_INIT;
            end else begin
                case (r_state)
                    S_INIT: begin
                        r_fv        <= FREE_SLOTS'(w_lim != '0);
                        r_uv        <= '0;
                        r_fb_mem[0] <= '0;
                        r_fe_mem[0] <= w_lim;
                        r_state     <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_s_tvalid) begin
                            r_cmd    <= i_s_tuser[0];
                            r_job    <= i_s_tdata[15:0];
                            r_req    <= i_s_tdata[31:16];
                            r_idx    <= '0;
                            r_bfound <= 1'b0;
                            r_uslotf <= 1'b0;
                            r_cnt    <= '0;
                            r_hitf   <= 1'b0;
                            r_leftf  <= 1'b0;
                            r_rightf <= 1'b0;
                            r_fslotf <= 1'b0;
                            r_state  <= (i_s_tuser[0] == CMD_ALLOC) ? S_ASCAN : S_FSCAN;
                        end
                    end
                    S_ASCAN: begin
                        if (w_ein_f && r_fv[w_e[FW-1:0]] && w_fits && w_better) begin
                            r_bfound <= 1'b1;
                            r_bidx   <= w_e[FW-1:0];
                            r_bsize  <= w_sz;
                            r_bbeg   <= r_fb_q;
                            r_bend   <= r_fe_q;
                        end
                        if (w_ein_u) begin
                            if (r_uv[w_e[UW-1:0]]) begin
                                r_cnt <= r_cnt + (UW+1)'(1);
                            end else if (!r_uslotf) begin
                                r_uslotf <= 1'b1;
                                r_uslot  <= w_e[UW-1:0];
                            end
                        end
                        if (r_idx == SW'(SCAN_N)) begin
                            r_state <= S_ACOMMIT;
                        end else begin
                            r_idx <= r_idx + SW'(1);
                        end
                    end
                    S_ACOMMIT: begin
                        r_state <= S_PUT;
                        r_rb    <= '0;
                        r_rz    <= '0;
                        if (!r_bfound) begin
                            r_rs <= ST_NOFIT;
                        end else if (!r_uslotf) begin
                            r_rs <= ST_FULL;
                        end else begin
                            r_uo_mem[r_uslot] <= r_job;
                            r_ub_mem[r_uslot] <= r_bbeg;
                            r_ue_mem[r_uslot] <= w_nbeg;
                            r_ua_mem[r_uslot] <= r_cnt[UW-1:0];
                            r_uv[r_uslot]     <= 1'b1;
                            r_fb_mem[r_bidx]  <= w_nbeg;
                            if (w_nbeg == r_bend) begin
                                r_fv[r_bidx] <= 1'b0;
                            end
                            r_rs <= ST_OK;
                            r_rb <= 16'(r_bbeg);
                            r_rz <= r_req;
                        end
                    end
                    S_FSCAN: begin
                        if (w_ein_u && r_uv[w_e[UW-1:0]] && (r_uo_q == r_job) &&
                            (!r_hitf || (r_ua_q < r_hitage))) begin
                            r_hitf   <= 1'b1;
                            r_hit    <= w_e[UW-1:0];
                            r_hitage <= r_ua_q;
                        end
                        if (r_idx == SW'(SCAN_N)) begin
                            r_state <= S_FREAD;
                        end else begin
                            r_idx <= r_idx + SW'(1);
                        end
                    end
                    S_FREAD: begin
                        if (!r_hitf) begin
                            r_rs    <= ST_NOID;
                            r_rb    <= '0;
                            r_rz    <= '0;
                            r_state <= S_PUT;
                        end else begin
                            r_state <= S_FLATCH;
                        end
                    end
                    S_FLATCH: begin
                        r_b     <= r_ub_q;
                        r_e     <= r_ue_q;
                        r_idx   <= '0;
                        r_state <= S_FSCAN2;
                    end
                    S_FSCAN2: begin
                        if (w_ein_f) begin
                            if (!r_fv[w_e[FW-1:0]]) begin
                                if (!r_fslotf) begin
                                    r_fslotf <= 1'b1;
                                    r_fslot  <= w_e[FW-1:0];
                                end
                            end else begin
                                if (r_fe_q == r_b) begin
                                    r_leftf <= 1'b1;
                                    r_left  <= w_e[FW-1:0];
                                end
                                if (r_fb_q == r_e) begin
                                    r_rightf <= 1'b1;
                                    r_right  <= w_e[FW-1:0];
                                    r_rend   <= r_fe_q;
                                end
                            end
                        end
                        if (r_idx == SW'(SCAN_N)) begin
                            r_state <= S_FCOMMIT;
                        end else begin
                            r_idx <= r_idx + SW'(1);
                        end
                    end
                    S_FCOMMIT: begin
                        r_idx   <= '0;
                        r_state <= S_AGE;
                        if (r_leftf && r_rightf) begin
                            r_fe_mem[r_left] <= r_rend;
                            r_fv[r_right]    <= 1'b0;
                        end else if (r_leftf) begin
                            r_fe_mem[r_left] <= r_e;
                        end else if (r_rightf) begin
                            r_fb_mem[r_right] <= r_b;
                        end else if (r_fslotf) begin
                            r_fb_mem[r_fslot] <= r_b;
                            r_fe_mem[r_fslot] <= r_e;
                            r_fv[r_fslot]     <= 1'b1;
                        end else begin
                            r_rs    <= ST_FULL;
                            r_rb    <= '0;
                            r_rz    <= '0;
                            r_state <= S_PUT;
                        end
                        if (r_leftf || r_rightf || r_fslotf) begin
                            r_uv[r_hit] <= 1'b0;
                        end
                    end
                    S_AGE: begin
                        if (w_ein_u && r_uv[w_e[UW-1:0]] && (r_ua_q > r_hitage)) begin
                            r_ua_mem[w_e[UW-1:0]] <= r_ua_q - UW'(1);
                        end
                        if (r_idx == SW'(SCAN_N)) begin
                            r_rs    <= ST_OK;
                            r_rb    <= 16'(r_b);
                            r_rz    <= 16'(r_e - r_b);
                            r_state <= S_PUT;
                        end else begin
                            r_idx <= r_idx + SW'(1);
                        end
                    end
                    S_PUT: begin
                        if (w_put) begin
                            r_ost   <= r_rs;
                            r_ob    <= r_rb;
                            r_oz    <= r_rz;
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_INIT;
                    end
                endcase
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_oz, r_ob};
    assign o_m_tuser  = r_ost;
    assign prdata     = (paddr[2] == REG_TOTAL_SIZE) ? 32'(r_total) : 32'd0;
    assign pready     = 1'b1;

endmodule
`default_nettype wire

// ===== hw/rtl/bfsa_checker.sv =====
// Port-level checker of the allocator and its bind
`default_nettype none
`include "best_fit_segment_allocator_macros.svh"
module bfsa_checker
    import bfsa_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser
);

    `BFSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
    `BFSA_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != ST_OK), o_m_tdata == 32'd0)
    `BFSA_ASSERT_NOW(a_ok_size, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == ST_OK), o_m_tdata[31:16] != 16'd0)
    `BFSA_ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

// ===== test/best_fit_segment_allocator_tb.sv =====
// Self-checking testbench for the best-fit segment allocator
`timescale 1ns / 100ps
`default_nettype none
module best_fit_segment_allocator_tb;
    import bfsa_pkg::*;

    localparam int NFREE = FREE_SLOTS_DEF;
    localparam int NUSED = USED_SLOTS_DEF;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        t_status     status;
        logic [15:0] begin_addr;
        logic [15:0] size;
    } grant_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [31:0]         i_s_tdata;   // job_id[15:0], req_size[31:16]
    logic [0:0]          i_s_tuser;   // cmd[0]
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [31:0]         o_m_tdata;   // block_begin[15:0], block_size[31:16]
    logic [1:0]          o_m_tuser;   // status[1:0]
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    best_fit_segment_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow allocator state
    logic [15:0] space_size;
    int          seg_lo [NFREE];
    int          seg_hi [NFREE];
    bit          seg_ok [NFREE];
    logic [15:0] blk_owner [NUSED];
    int          blk_lo [NUSED];
    int          blk_hi [NUSED];
    bit          blk_ok [NUSED];
    int          blk_rank [NUSED];

    grant_t      pending_grants[$];
    int          fail_count;
    int          beats_in;
    int          beats_out;
    int          ok_count;
    int          err_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void shadow_reinit(input logic [15:0] total);
        space_size = total;
        for (int i = 0; i < NFREE; i++) begin
            seg_lo[i] = 0;
            seg_hi[i] = 0;
            seg_ok[i] = 1'b0;
        end
        for (int i = 0; i < NUSED; i++) begin
            blk_owner[i] = '0;
            blk_lo[i] = 0;
            blk_hi[i] = 0;
            blk_ok[i] = 1'b0;
            blk_rank[i] = 0;
        end
        seg_hi[0] = int'(total);
        seg_ok[0] = total != 16'd0;
    endfunction

    function automatic grant_t shadow_alloc(input logic [15:0] job, input logic [15:0] req);
        grant_t g;
        int best;
        int slot;
        int bsize;
        int n;
        int sz;
        int b;
        g = '{ST_OK, 16'd0, 16'd0};
        best = -1;
        slot = -1;
        bsize = 0;
        n = 0;
        for (int i = 0; i < NFREE; i++) begin
            if (!seg_ok[i]) continue;
            sz = seg_hi[i] - seg_lo[i];
            if (req == 16'd0 || sz < int'(req)) continue;
            if (best < 0 || sz < bsize || (sz == bsize && seg_lo[i] < seg_lo[best])) begin
                best = i;
                bsize = sz;
            end
        end
        if (best < 0) begin
            g.status = ST_NOFIT;
            return g;
        end
        for (int i = 0; i < NUSED; i++) begin
            if (blk_ok[i]) n++;
            else if (slot < 0) slot = i;
        end
        if (slot < 0) begin
            g.status = ST_FULL;
            return g;
        end
        b = seg_lo[best];
        blk_owner[slot] = job;
        blk_lo[slot] = b;
        blk_hi[slot] = b + int'(req);
        blk_ok[slot] = 1'b1;
        blk_rank[slot] = n;
        seg_lo[best] = b + int'(req);
        if (seg_lo[best] == seg_hi[best]) seg_ok[best] = 1'b0;
        g.begin_addr = b[15:0];
        g.size = req;
        return g;
    endfunction

    function automatic grant_t shadow_release(input logic [15:0] job);
        grant_t g;
        int hit;
        int left;
        int right;
        int slot;
        int b;
        int e;
        int rank;
        g = '{ST_OK, 16'd0, 16'd0};
        hit = -1;
        left = -1;
        right = -1;
        slot = -1;
        for (int i = 0; i < NUSED; i++)
            if (blk_ok[i] && blk_owner[i] == job && (hit < 0 || blk_rank[i] < blk_rank[hit]))
                hit = i;
        if (hit < 0) begin
            g.status = ST_NOID;
            return g;
        end
        b = blk_lo[hit];
        e = blk_hi[hit];
        for (int i = 0; i < NFREE; i++) begin
            if (!seg_ok[i]) begin
                if (slot < 0) slot = i;
                continue;
            end
            if (seg_hi[i] == b) left = i;
            if (seg_lo[i] == e) right = i;
        end
        if (left >= 0 && right >= 0) begin
            seg_hi[left] = seg_hi[right];
            seg_ok[right] = 1'b0;
        end else if (left >= 0) begin
            seg_hi[left] = e;
        end else if (right >= 0) begin
            seg_lo[right] = b;
        end else if (slot >= 0) begin
            seg_lo[slot] = b;
            seg_hi[slot] = e;
            seg_ok[slot] = 1'b1;
        end else begin
            g.status = ST_FULL;
            return g;
        end
        rank = blk_rank[hit];
        blk_ok[hit] = 1'b0;
        blk_rank[hit] = 0;
        for (int i = 0; i < NUSED; i++)
            if (blk_ok[i] && blk_rank[i] > rank) blk_rank[i]--;
        g.begin_addr = b[15:0];
        g.size = 16'(e - b);
        return g;
    endfunction

    task automatic send_cmd(input logic cmd, input logic [15:0] job, input logic [15:0] req);
        grant_t g;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {req, job};
        i_s_tuser <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == CMD_ALLOC) g = shadow_alloc(job, req);
        else g = shadow_release(job);
        pending_grants = {pending_grants, g};
        beats_in++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_total_size(input logic [15:0] total);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(REG_TOTAL_SIZE) << 2;
        pwdata <= {16'd0, total};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_reinit(total);
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== total) begin
            $error("total_size readback: expected %0d actual %0d", total, prdata[15:0]);
            fail_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge i_clk)
        i_m_tready <= $urandom_range(99) >= recv_idle_pct;

    always @(posedge i_clk) begin
        grant_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            beats_out++;
            if (pending_grants.size() == 0) begin
                $error("result beat with nothing outstanding");
                fail_count++;
            end else begin
                want = pending_grants.pop_front();
                if (want.status == ST_OK) ok_count++;
                else err_count++;
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_m_tuser);
                    fail_count++;
                end
                if (o_m_tdata[15:0] !== want.begin_addr) begin
                    $error("block_begin: expected %0d actual %0d",
                           want.begin_addr, o_m_tdata[15:0]);
                    fail_count++;
                end
                if (o_m_tdata[31:16] !== want.size) begin
                    $error("block_size: expected %0d actual %0d",
                           want.size, o_m_tdata[31:16]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_edge_values();
        write_total_size(16'hFFFF);
        send_cmd(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_ALLOC, 16'h0000, 16'd1);
        send_cmd(CMD_FREE, 16'hFFFF, 16'd0);
        send_cmd(CMD_ALLOC, 16'h0001, 16'd0);
        send_cmd(CMD_FREE, 16'h1234, 16'hFFFF);
        write_total_size(16'd0);
        send_cmd(CMD_ALLOC, 16'h0002, 16'd1);
        send_cmd(CMD_FREE, 16'h0002, 16'd0);
        write_total_size(16'd1);
        send_cmd(CMD_ALLOC, 16'hAAAA, 16'd1);
        send_cmd(CMD_ALLOC, 16'h5555, 16'd1);
        send_cmd(CMD_FREE, 16'hAAAA, 16'd0);
    endtask

    task automatic test_fit_and_merge();
        write_total_size(16'd40);
        send_cmd(CMD_ALLOC, 16'd7, 16'd10);
        send_cmd(CMD_ALLOC, 16'd7, 16'd10);
        send_cmd(CMD_ALLOC, 16'd8, 16'd10);
        send_cmd(CMD_FREE, 16'd7, 16'd0);
        send_cmd(CMD_ALLOC, 16'd9, 16'd5);
        send_cmd(CMD_FREE, 16'd8, 16'd0);
        send_cmd(CMD_FREE, 16'd7, 16'd0);
        send_cmd(CMD_FREE, 16'd9, 16'd0);
        send_cmd(CMD_ALLOC, 16'd3, 16'd40);
    endtask

    task automatic test_used_table_full();
        write_total_size(16'd100);
        for (int i = 0; i < NUSED; i++) send_cmd(CMD_ALLOC, 16'(i), 16'd2);
        send_cmd(CMD_ALLOC, 16'd99, 16'd1);
        send_cmd(CMD_ALLOC, 16'd99, 16'd90);
        // hold off until the full table has answered
        wait_drained();
        for (int i = 0; i < NUSED; i += 2) send_cmd(CMD_FREE, 16'(i), 16'd0);
        for (int i = 1; i < NUSED; i += 2) send_cmd(CMD_FREE, 16'(i), 16'd0);
    endtask

    task automatic test_random(input int count, input int sidle, input int ridle,
                               input logic [15:0] total);
        logic [15:0] job_pool [8];
        int          live [$];
        int          r;
        int          pick;
        int          cap;
        logic [15:0] job;
        logic [15:0] req;
        job_pool = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'd1, 16'd2, 16'd3, 16'd4};
        write_total_size(total);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        cap = (int'(total) / 6 > 1) ? int'(total) / 6 : 1;
        for (int n = 0; n < count; n++) begin
            live.delete();
            for (int i = 0; i < NUSED; i++) if (blk_ok[i]) live = {live, i};
            r = $urandom_range(99);
            if (r < 40 && live.size() != 0) begin
                pick = live[$urandom_range(live.size() - 1)];
                send_cmd(CMD_FREE, blk_owner[pick], 16'($urandom));
            end else if (r < 45) begin
                send_cmd(CMD_FREE, 16'($urandom), 16'($urandom));
            end else begin
                job = ($urandom_range(4) == 0) ? 16'($urandom) : job_pool[$urandom_range(7)];
                pick = $urandom_range(99);
                if (pick < 75) req = 16'($urandom_range(1, cap));
                else if (pick < 90) req = 16'($urandom_range(1, int'(total) + 1));
                else req = 16'($urandom);
                send_cmd(CMD_ALLOC, job, req);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        beats_in = 0;
        beats_out = 0;
        ok_count = 0;
        err_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_cycles = 0;
        shadow_reinit(TOTAL_SIZE_RST);
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edge_values();
        test_fit_and_merge();
        test_used_table_full();
        test_random(270, 31, 71, 16'd300);
        test_random(270, 71, 31, 16'($urandom_range(2, 65534)));
        test_random(270, 0, 0, 16'hFFFF);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("covered %0d commands, %0d results (%0d granted/released, %0d errors)",
                 beats_in, beats_out, ok_count, err_count);
        $display("sizes 0, 1, 40, 100, 300, random and 65535; used table full; merges");
        if (fail_count == 0 && pending_grants.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
